@@ src/hsvg_pkg.sv @@
// Shared types and constants of the HSV gradient pattern generator.
package hsvg_pkg;

  localparam logic [2:0] MODE_WHITE = 3'd0;
  localparam logic [2:0] MODE_RED   = 3'd1;
  localparam logic [2:0] MODE_GREEN = 3'd2;
  localparam logic [2:0] MODE_BLUE  = 3'd3;
  localparam logic [2:0] MODE_HUE   = 3'd4;
  localparam logic [2:0] MODE_SAT   = 3'd5;
  localparam logic [2:0] MODE_VAL   = 3'd6;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_SLIDER = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [11:0] FRAME_RESET = 12'd512;
  localparam logic [6:0]  PERCENT_MAX = 7'd100;
  localparam logic [8:0]  DEGREES     = 9'd360;

  typedef struct packed {
    logic [2:0] mode;
    logic [8:0] slider;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } side_t;

endpackage

@@ src/hsvg_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module hsvg_div #(
  parameter int NW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [NW-1:0] quo_r [NW];
  logic [DW-1:0] den_r [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stg
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den;
      assign num_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign num_in = num_r[g-1];
      assign quo_in = quo_r[g-1];
    end

    assign trial = {rem_in, num_in[NW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      rem_r[g] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num_r[g] <= {num_in[NW-2:0], 1'b0};
      quo_r[g] <= {quo_in[NW-2:0], ge};
      den_r[g] <= den_in;
    end
  end

  assign quo = quo_r[NW-1];

endmodule

@@ src/hsv_gradient_pattern_generator_unit.sv @@
// Top level of the HSV gradient pattern generator.
//
//  channel  ports                                   handshake
//  input    start, busy, in_row, in_column          start && !busy
//  result   out_valid, out_red/green/blue           out_valid, one cycle
//  config   cfg_wr_en, cfg_index, cfg_data          cfg_wr_en
//
// One pixel per clock, busy is never raised. The latency is set by the
// input capture register and the pipelined dividers (one quotient bit per stage, LAT stages),
// followed by the hue modulo, product and channel stages.
// rst_n clears the valid bits and the configuration registers to their reset values.
// The receiver cannot stall; results leave on the cycle they are ready.
module hsv_gradient_pattern_generator_unit
  import hsvg_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_row,
  input  logic [11:0] in_column,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int CW  = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam int DW  = (CW > 7) ? CW : 7;
  localparam int HW  = CW + 9;
  localparam int FW  = DW + FRAC_BITS;
  localparam int LAT = (HW > FW) ? HW : FW;
  localparam int F   = FRAC_BITS;
  localparam int HS  = HW + 9;
  localparam longint unsigned HM = ((64'd1 << HS) + 64'd359) / 64'd360;
  localparam int XW  = F + 5;
  localparam int XS  = XW + 4;
  localparam longint unsigned XM = ((64'd1 << XS) + 64'd14) / 64'd15;

  logic [2:0]  mode_r;
  logic [8:0]  slider_r;
  logic [11:0] width_r;
  logic [11:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_WHITE;
      slider_r <= '0;
      width_r  <= FRAME_RESET;
      height_r <= FRAME_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE:   mode_r   <= cfg_data[2:0];
        REG_SLIDER: slider_r <= cfg_data[8:0];
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default:    mode_r   <= mode_r;
      endcase
    end
  end

  assign busy = 1'b0;

  // capture the transaction
  logic        in_vld_r;
  logic [11:0] row_r;
  logic [11:0] col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else        in_vld_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    row_r <= in_row;
    col_r <= in_column;
  end

  // prepare divider operands
  logic [CW-1:0] ii, jj, wm, hm, wd, hd, fall_w, fall_h, i_cl;
  logic [6:0]    pc;
  logic [DW-1:0] s_num, s_den, v_num, v_den;
  logic [HW-1:0] h_num;
  logic [LAT-1:0] s_quo, v_quo, h_quo;
  side_t         side;

  assign ii = row_r[CW-1:0];
  assign jj = col_r[CW-1:0];
  assign wm = width_r[CW-1:0];
  assign hm = height_r[CW-1:0];
  assign wd = (wm == '0) ? CW'(1) : wm;
  assign hd = (hm == '0) ? CW'(1) : hm;
  assign fall_w = (jj < wd) ? wd - jj : '0;
  assign fall_h = (ii < hd) ? hd - ii : '0;
  assign i_cl   = (ii > hd) ? hd : ii;
  assign pc     = (slider_r > 9'(PERCENT_MAX)) ? PERCENT_MAX : slider_r[6:0];
  assign h_num  = HW'(jj) * HW'(DEGREES);

  always_comb begin
    unique case (mode_r)
      MODE_HUE: begin
        s_num = DW'(fall_w);
        s_den = DW'(wd);
      end
      MODE_SAT: begin
        s_num = DW'(pc);
        s_den = DW'(PERCENT_MAX);
      end
      default: begin
        s_num = DW'(i_cl);
        s_den = DW'(hd);
      end
    endcase
    if (mode_r == MODE_VAL) begin
      v_num = DW'(pc);
      v_den = DW'(PERCENT_MAX);
    end else begin
      v_num = DW'(fall_h);
      v_den = DW'(hd);
    end
  end

  always_comb begin
    side.mode   = mode_r;
    side.slider = slider_r;
    side.red    = 8'hFF;
    side.green  = 8'hFF;
    side.blue   = 8'hFF;
    unique case (mode_r)
      MODE_RED: begin
        side.red   = slider_r[7:0];
        side.green = col_r[8:1];
        side.blue  = 8'hFF - row_r[8:1];
      end
      MODE_GREEN: begin
        side.red   = col_r[8:1];
        side.green = slider_r[7:0];
        side.blue  = 8'hFF - row_r[8:1];
      end
      MODE_BLUE: begin
        side.red   = col_r[8:1];
        side.green = 8'hFF - row_r[8:1];
        side.blue  = slider_r[7:0];
      end
      default: side.red = 8'hFF;
    endcase
  end

  hsvg_div #(.NW(LAT), .DW(DW)) u_div_s (
    .clk (clk),
    .num (LAT'({s_num, {F{1'b0}}})),
    .den (s_den),
    .quo (s_quo)
  );

  hsvg_div #(.NW(LAT), .DW(DW)) u_div_v (
    .clk (clk),
    .num (LAT'({v_num, {F{1'b0}}})),
    .den (v_den),
    .quo (v_quo)
  );

  hsvg_div #(.NW(LAT), .DW(DW)) u_div_h (
    .clk (clk),
    .num (LAT'(h_num)),
    .den (DW'(wd)),
    .quo (h_quo)
  );

  // hold side data alongside the dividers
  logic [LAT-1:0] dv_r;
  side_t          ds_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r <= '0;
    else        dv_r <= {dv_r[LAT-2:0], in_vld_r};
  end

  for (genvar g = 0; g < LAT; g++) begin : g_dly
    always_ff @(posedge clk) begin
      if (g == 0) ds_r[g] <= side;
      else        ds_r[g] <= ds_r[(g == 0) ? 0 : g-1];
    end
  end

  // hue modulo 360, saturation times value, ramp term, channel output
  side_t           sd1_r, sd2_r, sd3_r, sd4_r;
  logic [4:0]      vld_r;
  logic [HW-1:0]   hx1_r;
  logic [HW-9:0]   hq1_r;
  logic [F:0]      s1_r, v1_r, v2_r, c2_r, c3_r, m3_r, c4_r, m4_r, x4_r;
  logic [8:0]      h2_r;
  logic [2:0]      sx3_r, sx4_r;
  logic [F+6:0]    y3_r;

  logic [HW-1:0]   hx;
  logic [2*HW:0]   hprod;
  logic [HW-1:0]   hrem;
  logic [2*F+1:0]  cprod;
  logic [8:0]      hmod;
  logic [5:0]      tdist;
  logic [2:0]      sext;
  logic [2*XW:0]   xprod;

  assign hx    = (ds_r[LAT-1].mode == MODE_HUE) ? HW'(ds_r[LAT-1].slider) : h_quo[HW-1:0];
  assign hprod = (2*HW+1)'(hx) * (2*HW+1)'(HM);
  assign hrem  = hx1_r - HW'(hq1_r) * HW'(DEGREES);
  assign cprod = (2*F+2)'(v1_r) * (2*F+2)'(s1_r);
  assign xprod = (2*XW+1)'(y3_r[F+6:2]) * (2*XW+1)'(XM);

  always_comb begin
    if (h2_r >= 9'd240)      hmod = h2_r - 9'd240;
    else if (h2_r >= 9'd120) hmod = h2_r - 9'd120;
    else                     hmod = h2_r;
    tdist = (hmod >= 9'd60) ? 6'(hmod - 9'd60) : 6'(9'd60 - hmod);
    if (h2_r >= 9'd300)      sext = 3'd5;
    else if (h2_r >= 9'd240) sext = 3'd4;
    else if (h2_r >= 9'd180) sext = 3'd3;
    else if (h2_r >= 9'd120) sext = 3'd2;
    else if (h2_r >= 9'd60)  sext = 3'd1;
    else                     sext = 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[3:0], dv_r[LAT-1]};
  end

  always_ff @(posedge clk) begin
    hx1_r <= hx;
    hq1_r <= hprod[HS +: HW-8];
    s1_r  <= s_quo[F:0];
    v1_r  <= v_quo[F:0];
    sd1_r <= ds_r[LAT-1];

    h2_r  <= hrem[8:0];
    c2_r  <= cprod[F +: F+1];
    v2_r  <= v1_r;
    sd2_r <= sd1_r;

    y3_r  <= (F+7)'(c2_r) * (F+7)'(6'd60 - tdist);
    c3_r  <= c2_r;
    m3_r  <= v2_r - c2_r;
    sx3_r <= sext;
    sd3_r <= sd2_r;

    x4_r  <= xprod[XS +: F+1];
    c4_r  <= c3_r;
    m4_r  <= m3_r;
    sx4_r <= sx3_r;
    sd4_r <= sd3_r;
  end

  function automatic logic [7:0] to_byte(input logic [F:0] a);
    logic [F+8:0] p;
    p = {a, 8'd0} - (F+9)'(a);
    return p[F +: 8];
  endfunction

  logic [F:0] ra, ga, ba;
  logic [7:0] red_nxt, green_nxt, blue_nxt;

  always_comb begin
    unique case (sx4_r)
      3'd0: begin ra = c4_r; ga = x4_r; ba = '0;   end
      3'd1: begin ra = x4_r; ga = c4_r; ba = '0;   end
      3'd2: begin ra = '0;   ga = c4_r; ba = x4_r; end
      3'd3: begin ra = '0;   ga = x4_r; ba = c4_r; end
      3'd4: begin ra = x4_r; ga = '0;   ba = c4_r; end
      default: begin ra = c4_r; ga = '0; ba = x4_r; end
    endcase
    if (sd4_r.mode == MODE_HUE || sd4_r.mode == MODE_SAT || sd4_r.mode == MODE_VAL) begin
      red_nxt   = to_byte(ra + m4_r);
      green_nxt = to_byte(ga + m4_r);
      blue_nxt  = to_byte(ba + m4_r);
    end else begin
      red_nxt   = sd4_r.red;
      green_nxt = sd4_r.green;
      blue_nxt  = sd4_r.blue;
    end
  end

  logic [7:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_valid = vld_r[4];
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

@@ verif/hsv_gradient_pattern_generator_unit_tb.sv @@
// Testbench of the HSV gradient pattern generator: directed table, then random pixels.
`timescale 1ns / 1ps
module hsv_gradient_pattern_generator_unit_tb;
  import hsvg_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 120;

  typedef struct {
    logic [2:0]  mode;
    logic [8:0]  slider;
    logic [11:0] width;
    logic [11:0] height;
    logic [11:0] row;
    logic [11:0] column;
    bit          pinned;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_row_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [11:0] in_row = '0;
  logic [11:0] in_column = '0;
  logic        out_valid;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_MODE;
  logic [11:0] cfg_data = '0;

  logic [2:0]  cur_mode;
  logic [8:0]  cur_slider;
  logic [11:0] cur_width;
  logic [11:0] cur_height;

  rgb_t pending_pixels[$];
  int   error_count = 0;
  int   quiet_cycles = 0;
  int   idle_pct = 0;

  hsv_gradient_pattern_generator_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_row(in_row), .in_column(in_column),
    .out_valid(out_valid), .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned ramp_frac(longint unsigned num, longint unsigned den);
    if (num > den) num = den;
    return (num << 16) / den;
  endfunction

  function automatic longint unsigned pct_frac(longint unsigned p);
    if (p > 100) p = 100;
    return (p << 16) / 100;
  endfunction

  function automatic logic [7:0] chan_byte(longint unsigned x);
    return 8'((x * 255) >> 16);
  endfunction

  function automatic rgb_t hsv_to_rgb(longint unsigned h, longint unsigned s,
                                      longint unsigned v);
    longint unsigned c, x, m, hm, t, r, g, b;
    rgb_t px;
    h = h % 360;
    c = (v * s) >> 16;
    hm = h % 120;
    t = (hm >= 60) ? hm - 60 : 60 - hm;
    x = (c * (60 - t)) / 60;
    m = v - c;
    case (h / 60)
      0: begin r = c; g = x; b = 0; end
      1: begin r = x; g = c; b = 0; end
      2: begin r = 0; g = c; b = x; end
      3: begin r = 0; g = x; b = c; end
      4: begin r = x; g = 0; b = c; end
      default: begin r = c; g = 0; b = x; end
    endcase
    px.red = chan_byte(r + m);
    px.green = chan_byte(g + m);
    px.blue = chan_byte(b + m);
    return px;
  endfunction

  function automatic rgb_t pattern_pixel(logic [11:0] i, logic [11:0] j);
    longint unsigned w, hg, hue, fall_w, fall_h;
    logic [7:0] fixed, down, across;
    rgb_t px;
    w = (cur_width == 0) ? 1 : cur_width;
    hg = (cur_height == 0) ? 1 : cur_height;
    fixed = cur_slider[7:0];
    down = 8'(255 - (i >> 1));
    across = 8'(j >> 1);
    hue = ((360 * longint'(j)) / w) % 360;
    fall_w = (j < w) ? w - j : 0;
    fall_h = (i < hg) ? hg - i : 0;
    case (cur_mode)
      MODE_RED:   px = '{fixed, across, down};
      MODE_GREEN: px = '{across, fixed, down};
      MODE_BLUE:  px = '{across, down, fixed};
      MODE_HUE:   px = hsv_to_rgb(cur_slider, ramp_frac(fall_w, w), ramp_frac(fall_h, hg));
      MODE_SAT:   px = hsv_to_rgb(hue, pct_frac(cur_slider), ramp_frac(fall_h, hg));
      MODE_VAL:   px = hsv_to_rgb(hue, ramp_frac(i, hg), pct_frac(cur_slider));
      default:    px = '{8'hFF, 8'hFF, 8'hFF};
    endcase
    return px;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    rgb_t exp_px;
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** hsv_gradient_pattern_generator_unit: FAILED **");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel with no transaction pending");
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_red !== exp_px.red)
          report_mismatch($sformatf("red %0d exp %0d", out_red, exp_px.red));
        if (out_green !== exp_px.green)
          report_mismatch($sformatf("green %0d exp %0d", out_green, exp_px.green));
        if (out_blue !== exp_px.blue)
          report_mismatch($sformatf("blue %0d exp %0d", out_blue, exp_px.blue));
      end
    end
  end

  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_MODE:   cur_mode = data[2:0];
      REG_SLIDER: cur_slider = data[8:0];
      REG_WIDTH:  cur_width = data;
      default:    cur_height = data;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_setting(logic [2:0] m, logic [8:0] s, logic [11:0] w, logic [11:0] h);
    drain_pipeline();
    write_reg(REG_MODE, {9'd0, m});
    write_reg(REG_SLIDER, {3'd0, s});
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic send_pixel(logic [11:0] r, logic [11:0] c, bit pinned, rgb_t pinned_px);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_row <= r;
    in_column <= c;
    do @(posedge clk); while (busy);
    pending_pixels.push_back(pinned ? pinned_px : pattern_pixel(r, c));
  endtask

  pixel_row_t directed[] = '{
    '{MODE_WHITE, 9'd0,   12'd512,  12'd512,  12'd0,    12'd0,    1, 8'd255, 8'd255, 8'd255},
    '{MODE_WHITE, 9'd0,   12'd512,  12'd512,  12'hFFF,  12'hFFF,  1, 8'd255, 8'd255, 8'd255},
    '{3'd7,       9'h1FF, 12'd512,  12'd512,  12'd100,  12'd200,  1, 8'd255, 8'd255, 8'd255},
    '{MODE_RED,   9'h1FF, 12'd512,  12'd512,  12'd0,    12'd0,    1, 8'd255, 8'd0,   8'd255},
    '{MODE_RED,   9'h1FF, 12'd512,  12'd512,  12'hFFF,  12'hFFF,  1, 8'd255, 8'd255, 8'd0},
    '{MODE_GREEN, 9'h0AA, 12'd512,  12'd512,  12'd0,    12'd0,    1, 8'd0,   8'hAA,  8'd255},
    '{MODE_GREEN, 9'h155, 12'd1,    12'd1,    12'd513,  12'd77,   0, 0, 0, 0},
    '{MODE_BLUE,  9'd0,   12'd512,  12'd512,  12'd0,    12'd0,    1, 8'd0,   8'd255, 8'd0},
    '{MODE_BLUE,  9'h0FF, 12'd4095, 12'd4095, 12'd2049, 12'd3333, 0, 0, 0, 0},
    '{MODE_HUE,   9'd0,   12'd512,  12'd512,  12'd0,    12'd0,    1, 8'd255, 8'd0,   8'd0},
    '{MODE_HUE,   9'd360, 12'd512,  12'd512,  12'd0,    12'd0,    1, 8'd255, 8'd0,   8'd0},
    '{MODE_HUE,   9'd120, 12'd512,  12'd512,  12'd0,    12'd0,    1, 8'd0,   8'd255, 8'd0},
    '{MODE_HUE,   9'h1FF, 12'd512,  12'd512,  12'd100,  12'd300,  0, 0, 0, 0},
    '{MODE_HUE,   9'd90,  12'd512,  12'd512,  12'd512,  12'd600,  1, 8'd0,   8'd0,   8'd0},
    '{MODE_HUE,   9'd200, 12'd0,    12'd0,    12'd0,    12'd0,    0, 0, 0, 0},
    '{MODE_SAT,   9'd100, 12'd512,  12'd512,  12'd0,    12'd0,    1, 8'd255, 8'd0,   8'd0},
    '{MODE_SAT,   9'h1FF, 12'd512,  12'd512,  12'd0,    12'd256,  0, 0, 0, 0},
    '{MODE_SAT,   9'd0,   12'd512,  12'd512,  12'd0,    12'd300,  1, 8'd255, 8'd255, 8'd255},
    '{MODE_SAT,   9'd37,  12'd4095, 12'd4095, 12'd4095, 12'hFFF,  0, 0, 0, 0},
    '{MODE_VAL,   9'd0,   12'd512,  12'd512,  12'd100,  12'd100,  1, 8'd0,   8'd0,   8'd0},
    '{MODE_VAL,   9'd100, 12'd512,  12'd512,  12'd0,    12'd0,    1, 8'd255, 8'd255, 8'd255},
    '{MODE_VAL,   9'd300, 12'd512,  12'd512,  12'hFFF,  12'd0,    1, 8'd255, 8'd0,   8'd0},
    '{MODE_VAL,   9'd55,  12'd7,    12'd3,    12'd2,    12'd5,    0, 0, 0, 0}
  };

  initial begin
    pixel_row_t dr;
    rgb_t px;
    logic [2:0] m;
    logic [11:0] w, h, r, c;
    cur_mode = MODE_WHITE;
    cur_slider = '0;
    cur_width = FRAME_RESET;
    cur_height = FRAME_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      dr = directed[k];
      if (dr.mode != cur_mode || dr.slider != cur_slider ||
          dr.width != cur_width || dr.height != cur_height)
        load_setting(dr.mode, dr.slider, dr.width, dr.height);
      px = '{dr.red, dr.green, dr.blue};
      send_pixel(dr.row, dr.column, dr.pinned, px);
    end

    for (int k = 0; k < 40; k++) begin
      case (k % 4)
        0: idle_pct = 0;
        1: idle_pct = 50;
        2: idle_pct = 23;
        default: idle_pct = (k % 8 == 3) ? 0 : 50;
      endcase
      m = 3'($urandom_range(7));
      case ($urandom_range(3))
        0: begin w = 12'($urandom_range(1, 16)); h = 12'($urandom_range(1, 16)); end
        1: begin w = 12'($urandom); h = 12'($urandom); end
        2: begin w = 12'hFFF; h = 12'($urandom_range(0, 1)); end
        default: begin w = 12'($urandom_range(64, 1024)); h = 12'($urandom_range(64, 1024)); end
      endcase
      load_setting(m, 9'($urandom), w, h);
      repeat (38) begin
        if ($urandom_range(9) < 8) begin
          r = 12'($urandom_range(0, (h == 0) ? 0 : h - 1));
          c = 12'($urandom_range(0, (w == 0) ? 0 : w - 1));
        end else begin
          r = 12'($urandom);
          c = 12'($urandom);
        end
        send_pixel(r, c, 0, px);
      end
    end

    drain_pipeline();
    if (error_count == 0) $display("** hsv_gradient_pattern_generator_unit: PASSED **");
    else $display("** hsv_gradient_pattern_generator_unit: FAILED **");
    $finish;
  end

endmodule

@@ hsv_gradient_pattern_generator_unit.f @@
src/hsvg_pkg.sv
src/hsvg_div.sv
src/hsv_gradient_pattern_generator_unit.sv
verif/hsv_gradient_pattern_generator_unit_tb.sv
